// File: rtl/safs_pkg.sv
`timescale 1ns / 1ps

package safs_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    // field and register widths
    localparam int OP_W       = 2;
    localparam int ELAPSED_W  = 16;
    localparam int TARGET_W   = 8;
    localparam int FRAME_W    = 6;
    localparam int SPEED_W    = 10;
    localparam int FCOUNT_W   = 7;
    localparam int LOOP_W     = 6;
    localparam int LERP_W     = 8;
    localparam int OVR_W      = 11;
    localparam int TIMER_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // request opcodes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_REWIND = 2'd1;
    localparam logic [OP_W-1:0] OP_SET    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_SPEED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LERP_PERCENT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_OVERRIDE = 3'd6;

    localparam logic [SPEED_W-1:0] HIGH_SPEED_RST = 10'd10;
    localparam logic [SPEED_W-1:0] LOW_SPEED_RST  = 10'd5;
    localparam logic [LERP_W-1:0]  LERP_OFF       = 8'hFF;
    localparam logic [OVR_W-1:0]   OVERRIDE_NONE  = 11'd1024;
    localparam logic [SPEED_W-1:0] SPEED_MAX      = 10'd1023;

    localparam logic [TIMER_W-1:0] TIMER_STEP = 17'd100;

    // floor(a/100) == (a * RECIP_100) >> RECIP_SHIFT for a < 2^17
    localparam logic [17:0] RECIP_100   = 18'd167773;
    localparam int          RECIP_SHIFT = 24;

    // commands to the advance unit
    localparam logic [2:0] ADV_NONE   = 3'd0;
    localparam logic [2:0] ADV_REWIND = 3'd1;
    localparam logic [2:0] ADV_SET    = 3'd2;
    localparam logic [2:0] ADV_MUL    = 3'd3;
    localparam logic [2:0] ADV_LOAD   = 3'd4;
    localparam logic [2:0] ADV_STEP   = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
    } adv_ctrl_t;

    typedef struct packed {
        logic busy;
        logic finished;
    } adv_stat_t;

endpackage

// File: rtl/safs_speed.sv
`timescale 1ns / 1ps

module safs_speed (
    input  logic                                clk,
    input  logic [safs_pkg::SPEED_W-1:0]        high_speed,
    input  logic [safs_pkg::SPEED_W-1:0]        low_speed,
    input  logic signed [safs_pkg::LERP_W-1:0]  lerp_percent,
    input  logic [safs_pkg::OVR_W-1:0]          speed_override,
    output logic [safs_pkg::SPEED_W-1:0]        effective_speed
);
    import safs_pkg::*;

    // stage 1: blend product
    logic signed [10:0] diff;
    logic signed [18:0] diff_ext;
    logic signed [18:0] lerp_ext;
    logic signed [18:0] prod_next;
    logic signed [18:0] prod_reg;
    logic               ovr1_reg;
    logic [SPEED_W-1:0] ovr_val1_reg;
    logic               lerp_off1_reg;
    logic [SPEED_W-1:0] high1_reg;
    logic [SPEED_W-1:0] low1_reg;

    // stage 2: divide by 100 through the reciprocal
    logic [18:0]        neg_prod;
    logic [16:0]        mag;
    logic [34:0]        recip_prod;
    logic [10:0]        quot_reg;
    logic               neg2_reg;
    logic               ovr2_reg;
    logic [SPEED_W-1:0] ovr_val2_reg;
    logic               lerp_off2_reg;
    logic [SPEED_W-1:0] high2_reg;
    logic [SPEED_W-1:0] low2_reg;

    // stage 3: add, saturate, select
    logic signed [12:0] blend;
    logic [SPEED_W-1:0] blend_sat;
    logic [SPEED_W-1:0] speed_next;
    logic [SPEED_W-1:0] speed_reg;

    assign diff      = $signed({1'b0, high_speed}) - $signed({1'b0, low_speed});
    assign diff_ext  = 19'(diff);
    assign lerp_ext  = 19'(lerp_percent);
    assign prod_next = diff_ext * lerp_ext;

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        ovr1_reg      <= (speed_override != OVERRIDE_NONE);
        ovr_val1_reg  <= (speed_override > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                              : speed_override[SPEED_W-1:0];
        lerp_off1_reg <= (lerp_percent == $signed(LERP_OFF));
        high1_reg     <= high_speed;
        low1_reg      <= low_speed;
    end

    assign neg_prod   = 19'(-prod_reg);
    assign mag        = prod_reg[18] ? neg_prod[16:0] : prod_reg[16:0];
    assign recip_prod = 35'(mag) * 35'(RECIP_100);

    always_ff @(posedge clk)
    begin
        quot_reg      <= recip_prod[RECIP_SHIFT +: 11];
        neg2_reg      <= prod_reg[18];
        ovr2_reg      <= ovr1_reg;
        ovr_val2_reg  <= ovr_val1_reg;
        lerp_off2_reg <= lerp_off1_reg;
        high2_reg     <= high1_reg;
        low2_reg      <= low1_reg;
    end

    always_comb
    begin
        if (neg2_reg)
        begin
            blend = $signed({3'b000, low2_reg}) - $signed({2'b00, quot_reg});
        end
        else
        begin
            blend = $signed({3'b000, low2_reg}) + $signed({2'b00, quot_reg});
        end
        if (blend < 0)
        begin
            blend_sat = '0;
        end
        else if (blend > $signed({3'b000, SPEED_MAX}))
        begin
            blend_sat = SPEED_MAX;
        end
        else
        begin
            blend_sat = blend[SPEED_W-1:0];
        end
        if (ovr2_reg)
        begin
            speed_next = ovr_val2_reg;
        end
        else if (lerp_off2_reg)
        begin
            speed_next = high2_reg;
        end
        else
        begin
            speed_next = blend_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
    end

    assign effective_speed = speed_reg;

endmodule

// File: rtl/safs_advance.sv
`timescale 1ns / 1ps

module safs_advance #(
    parameter int MAX_FRAMES = safs_pkg::MAX_FRAMES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  safs_pkg::adv_ctrl_t               ctrl,
    input  logic [safs_pkg::FCOUNT_W-1:0]     frame_count,
    input  logic [safs_pkg::LOOP_W-1:0]       loop_start,
    input  logic [safs_pkg::ELAPSED_W-1:0]    elapsed,
    input  logic [safs_pkg::TARGET_W-1:0]     target_frame,
    input  logic [safs_pkg::SPEED_W-1:0]      speed,
    output safs_pkg::adv_stat_t               stat,
    output logic [safs_pkg::FRAME_W-1:0]      frame_index
);
    import safs_pkg::*;

    localparam int CNT_MAX = (MAX_FRAMES < 127) ? MAX_FRAMES : 127;
    localparam int POS_W   = $clog2(CNT_MAX);
    localparam int MUL_W   = ELAPSED_W + SPEED_W;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic               fin_reg;
    logic               fin_next;
    logic [MUL_W-1:0]   mul_reg;

    logic [8:0]         count9;
    logic [8:0]         pos9;
    logic [8:0]         loop9;
    logic [8:0]         target9;
    logic [POS_W-1:0]   wrap_pos;
    logic [POS_W-1:0]   set_pos;
    logic [32:0]        scaled;
    logic [7:0]         pos_ext;

    assign count9  = ({2'b00, frame_count} > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES)
                                                             : {2'b00, frame_count};
    assign pos9    = 9'(pos_reg);
    assign loop9   = 9'(loop_start);
    assign target9 = 9'(target_frame);
    assign wrap_pos = (loop9 < count9) ? POS_W'(loop9) : '0;
    assign set_pos  = (target9 < count9) ? POS_W'(target9) : '0;

    // elapsed * speed * 100 in Q17.16, keep the integer part
    assign scaled = 33'(mul_reg) * 33'(100);

    always_comb
    begin
        pos_next   = pos_reg;
        timer_next = timer_reg;
        fin_next   = fin_reg;
        unique case (ctrl.cmd)
            ADV_REWIND:
            begin
                pos_next   = '0;
                timer_next = '0;
                fin_next   = 1'b0;
            end
            ADV_SET:
            begin
                pos_next   = set_pos;
                timer_next = '0;
            end
            ADV_LOAD:
            begin
                timer_next = timer_reg + scaled[32:16];
                fin_next   = 1'b0;
            end
            ADV_STEP:
            begin
                timer_next = timer_reg - TIMER_STEP;
                if ((pos9 + 9'd1) >= count9)
                begin
                    pos_next = wrap_pos;
                    fin_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            timer_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            timer_reg <= timer_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == ADV_MUL)
        begin
            mul_reg <= MUL_W'(elapsed) * MUL_W'(speed);
        end
    end

    assign stat.busy     = (timer_reg > TIMER_STEP);
    assign stat.finished = fin_reg;
    assign pos_ext       = 8'(pos_reg);
    assign frame_index   = pos_ext[FRAME_W-1:0];

endmodule

// File: rtl/sprite_animation_frame_sequencer_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// request   in         in_valid / in_stall   op, elapsed, target_frame
// result    out        out_valid / out_stall frame_index, finished, effective_speed
// config    in         cfg_we                cfg_index, cfg_data
//
// one request at a time; in_stall stays high from acceptance until the result
// is registered. rewind, set frame and paused ticks pass the wait states, dispatch
// and done; a running tick adds a load and N frame advances, one per cycle through
// the shared subtract-and-compare step on the phase timer (N <= 1023).
// rst_n asynchronously clears position, timer and finished flag, resets registers.
// a held result blocks only the hand-off of the next result.
module sprite_animation_frame_sequencer_top #(
    parameter int MAX_FRAMES = safs_pkg::MAX_FRAMES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [safs_pkg::OP_W-1:0]          op,
    input  logic [safs_pkg::ELAPSED_W-1:0]     elapsed,
    input  logic [safs_pkg::TARGET_W-1:0]      target_frame,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [safs_pkg::FRAME_W-1:0]       frame_index,
    output logic                               finished,
    output logic [safs_pkg::SPEED_W-1:0]       effective_speed,
    input  logic                               cfg_we,
    input  logic [safs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [safs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import safs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT1 = 3'd1;
    localparam logic [2:0] S_WAIT2 = 3'd2;
    localparam logic [2:0] S_DISP  = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_WAIT3 = 3'd7;

    logic                     run_enable_reg;
    logic [FCOUNT_W-1:0]      frame_count_reg;
    logic [LOOP_W-1:0]        loop_start_reg;
    logic [SPEED_W-1:0]       high_speed_reg;
    logic [SPEED_W-1:0]       low_speed_reg;
    logic signed [LERP_W-1:0] lerp_percent_reg;
    logic [OVR_W-1:0]         speed_override_reg;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [OP_W-1:0]          op_reg;
    logic [ELAPSED_W-1:0]     elapsed_reg;
    logic [TARGET_W-1:0]      target_reg;

    logic                     out_valid_reg;
    logic [FRAME_W-1:0]       frame_out_reg;
    logic                     fin_out_reg;
    logic [SPEED_W-1:0]       speed_out_reg;

    logic                     in_take;
    logic                     out_free;
    logic                     out_load;
    logic [SPEED_W-1:0]       speed;
    logic [FRAME_W-1:0]       adv_frame;
    adv_ctrl_t                adv_ctrl;
    adv_stat_t                adv_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg     <= 1'b0;
            frame_count_reg    <= '0;
            loop_start_reg     <= '0;
            high_speed_reg     <= HIGH_SPEED_RST;
            low_speed_reg      <= LOW_SPEED_RST;
            lerp_percent_reg   <= $signed(LERP_OFF);
            speed_override_reg <= OVERRIDE_NONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RUN_ENABLE:     run_enable_reg     <= cfg_data[0];
                REG_FRAME_COUNT:    frame_count_reg    <= cfg_data[FCOUNT_W-1:0];
                REG_LOOP_START:     loop_start_reg     <= cfg_data[LOOP_W-1:0];
                REG_HIGH_SPEED:     high_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_LOW_SPEED:      low_speed_reg      <= cfg_data[SPEED_W-1:0];
                REG_LERP_PERCENT:   lerp_percent_reg   <= $signed(cfg_data[LERP_W-1:0]);
                REG_SPEED_OVERRIDE: speed_override_reg <= cfg_data[OVR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    safs_speed u_speed (
        .clk             (clk),
        .high_speed      (high_speed_reg),
        .low_speed       (low_speed_reg),
        .lerp_percent    (lerp_percent_reg),
        .speed_override  (speed_override_reg),
        .effective_speed (speed)
    );

    safs_advance #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_advance (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (adv_ctrl),
        .frame_count  (frame_count_reg),
        .loop_start   (loop_start_reg),
        .elapsed      (elapsed_reg),
        .target_frame (target_reg),
        .speed        (speed),
        .stat         (adv_stat),
        .frame_index  (adv_frame)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // the speed pipeline settles during the three wait states, even after a
    // register write at the edge that takes the request
    always_comb
    begin
        state_next   = state_reg;
        adv_ctrl.cmd = ADV_NONE;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_WAIT1;
                end
            end
            S_WAIT1:
            begin
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                state_next = S_WAIT3;
            end
            S_WAIT3:
            begin
                state_next = S_DISP;
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (run_enable_reg)
                        begin
                            adv_ctrl.cmd = ADV_MUL;
                            state_next   = S_LOAD;
                        end
                    end
                    OP_REWIND: adv_ctrl.cmd = ADV_REWIND;
                    OP_SET:    adv_ctrl.cmd = ADV_SET;
                    default:
                    begin
                    end
                endcase
            end
            S_LOAD:
            begin
                adv_ctrl.cmd = ADV_LOAD;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                if (adv_stat.busy)
                begin
                    adv_ctrl.cmd = ADV_STEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg      <= op;
            elapsed_reg <= elapsed;
            target_reg  <= target_frame;
        end
        if (out_load)
        begin
            frame_out_reg <= adv_frame;
            fin_out_reg   <= adv_stat.finished;
            speed_out_reg <= speed;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_index     = frame_out_reg;
    assign finished        = fin_out_reg;
    assign effective_speed = speed_out_reg;

endmodule
